/* hdl/assert_macros.svh */
// Assertion helpers shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

/* hdl/pss_pkg.sv */
`timescale 1ns / 1ps

package pss_pkg;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_PLAY  = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_TRIG  = 3'd3,
    ACT_WRITE = 3'd4
  } pss_act_e;

  localparam logic [7:0] NOTE_HOLD   = 8'd255;
  localparam logic [7:0] NOTE_REST   = 8'd0;
  localparam logic [1:0] VOICE_FX    = 2'd3;
  localparam logic [1:0] VOICE_LAST  = 2'd2;
  localparam logic [7:0] FX_VOL_STEP = 8'd6;
  localparam logic [7:0] FX_VOL_MAX  = 8'd60;
  localparam int         FX_FLOOR    = 60;
  localparam int         FX_CEIL     = 65535;
  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [3:0][7:0] FPS_RESET = {8'd8, 8'd7, 8'd12, 8'd11};

  typedef struct packed {
    logic [2:0]        action;
    logic [1:0]        song;
    logic [5:0]        transpose;
    logic [11:0]       effect_freq;
    logic [4:0]        effect_life;
    logic signed [7:0] effect_slide;
    logic [2:0]        effect_duty;
    logic [1:0]        pattern_voice;
    logic [4:0]        pattern_index;
    logic [7:0]        pattern_note;
  } pss_in_t;

  // one issued slot: a music voice read, the effect voice or a stop slot
  typedef struct packed {
    logic        vld;
    logic        stop;
    logic [1:0]  ch;
    logic        fin;
    logic [5:0]  transp;
    logic        eff_emit;
    logic        eff_sil;
    logic [15:0] eff_pitch;
    logic [5:0]  eff_vol;
    logic [2:0]  eff_duty;
  } pss_slot_t;

  typedef struct packed {
    logic [1:0]  voice;
    logic        silence;
    logic [15:0] pitch;
    logic [5:0]  volume;
    logic [2:0]  duty;
    logic        last;
  } pss_res_t;

  function automatic logic [5:0] music_vol(input logic [1:0] ch);
    logic [5:0] v;
    case (ch)
      2'd0:    v = 6'd46;
      2'd1:    v = 6'd54;
      2'd2:    v = 6'd30;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] music_duty(input logic [1:0] ch);
    logic [2:0] d;
    case (ch)
      2'd0:    d = 3'd4;
      2'd1:    d = 3'd2;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

/* hdl/pss_ram.sv */
`timescale 1ns / 1ps

module pss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pss_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pss_ctrl #(
  parameter int unsigned STEPS = 32,
  parameter int unsigned SONGS = 4,
  localparam int unsigned SW   = $clog2(STEPS),
  localparam int unsigned AW   = $clog2(SONGS * 3 * STEPS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  pss_pkg::pss_in_t   in_i,
  output logic               in_rdy_o,
  input  logic [3:0][7:0]    fps_i,
  input  logic               room_i,
  output pss_pkg::pss_slot_t slot_o,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic [7:0]         wdata_o,
  output logic               re_o,
  output logic [AW-1:0]      raddr_o
);

  // song state
  logic          playing_q, playing_d;
  logic [1:0]    song_q, song_d;
  logic [5:0]    transp_q, transp_d;
  logic [SW-1:0] step_q, step_d;
  logic [7:0]    fcnt_q, fcnt_d;
  // effect state
  logic [15:0]       efreq_q, efreq_d;
  logic [4:0]        erem_q, erem_d;
  logic signed [7:0] eslide_q, eslide_d;
  logic [2:0]        eduty_q, eduty_d;
  // job being issued
  logic          busy_q, busy_d;
  logic          jstop_q, jstop_d;
  logic [1:0]    slot_q, slot_d;
  logic [1:0]    jsong_q, jsong_d;
  logic [SW-1:0] jstep_q, jstep_d;
  logic [5:0]    jtransp_q, jtransp_d;
  logic          jemit_q, jemit_d;
  logic          jsil_q, jsil_d;
  logic [15:0]   jpitch_q, jpitch_d;
  logic [5:0]    jvol_q, jvol_d;
  logic [2:0]    jduty_q, jduty_d;

  logic        fire, fin, acc;
  logic [7:0]  fcnt_inc;
  logic        adv;
  logic [SW-1:0] step_nx;
  logic [4:0]  rem_n;
  logic signed [17:0] fsum;
  logic [15:0] fclamp;
  logic [7:0]  vprod;
  logic [5:0]  vol;

  assign fire     = busy_q & room_i;
  assign fin      = jstop_q ? (slot_q == pss_pkg::VOICE_LAST) : (slot_q == pss_pkg::VOICE_FX);
  assign in_rdy_o = ~busy_q | (fire & fin);
  assign acc      = in_vld_i & in_rdy_o;

  // frame tick arithmetic
  assign fcnt_inc = fcnt_q + 8'd1;
  assign adv      = playing_q && (fcnt_inc >= fps_i[song_q]);
  assign step_nx  = (step_q == SW'(STEPS - 1)) ? '0 : step_q + 1'b1;
  assign rem_n    = erem_q - 5'd1;
  assign fsum     = $signed({2'b00, efreq_q}) + 18'(eslide_q);
  assign vprod    = {3'b000, rem_n} * pss_pkg::FX_VOL_STEP;

  always_comb begin
    if (fsum < 18'sd60) begin
      fclamp = 16'(pss_pkg::FX_FLOOR);
    end else if (fsum > 18'sd65535) begin
      fclamp = 16'(pss_pkg::FX_CEIL);
    end else begin
      fclamp = fsum[15:0];
    end
    vol = (vprod > pss_pkg::FX_VOL_MAX) ? pss_pkg::FX_VOL_MAX[5:0] : vprod[5:0];
  end

  always_comb begin
    playing_d = playing_q;
    song_d    = song_q;
    transp_d  = transp_q;
    step_d    = step_q;
    fcnt_d    = fcnt_q;
    efreq_d   = efreq_q;
    erem_d    = erem_q;
    eslide_d  = eslide_q;
    eduty_d   = eduty_q;
    busy_d    = busy_q;
    jstop_d   = jstop_q;
    slot_d    = slot_q;
    jsong_d   = jsong_q;
    jstep_d   = jstep_q;
    jtransp_d = jtransp_q;
    jemit_d   = jemit_q;
    jsil_d    = jsil_q;
    jpitch_d  = jpitch_q;
    jvol_d    = jvol_q;
    jduty_d   = jduty_q;
    we_o      = 1'b0;
    waddr_o   = AW'((int'(in_i.song) * 3 + int'(in_i.pattern_voice)) * STEPS
                    + int'(in_i.pattern_index));
    wdata_o   = in_i.pattern_note;

    if (fire) begin
      if (fin) begin
        busy_d = 1'b0;
      end else begin
        slot_d = slot_q + 2'd1;
      end
    end

    if (acc) begin
      unique case (in_i.action)
        pss_pkg::ACT_TICK: begin
          busy_d    = 1'b1;
          jstop_d   = 1'b0;
          jsong_d   = song_q;
          jtransp_d = transp_q;
          jstep_d   = adv ? step_nx : step_q;
          slot_d    = adv ? 2'd0 : pss_pkg::VOICE_FX;
          if (playing_q) begin
            fcnt_d = adv ? 8'd0 : fcnt_inc;
            step_d = adv ? step_nx : step_q;
          end
          jemit_d  = (erem_q != 5'd0);
          jsil_d   = (rem_n == 5'd0);
          jpitch_d = (rem_n == 5'd0) ? 16'd0 : fclamp;
          jvol_d   = (rem_n == 5'd0) ? 6'd0 : vol;
          jduty_d  = (rem_n == 5'd0) ? 3'd0 : eduty_q;
          if (erem_q != 5'd0) begin
            erem_d  = rem_n;
            efreq_d = fclamp;
          end
        end
        pss_pkg::ACT_PLAY: begin
          if ((int'(in_i.song) < SONGS) && !(playing_q && song_q == in_i.song
                                             && transp_q == in_i.transpose)) begin
            song_d    = in_i.song;
            transp_d  = in_i.transpose;
            playing_d = 1'b1;
            step_d    = '0;
            fcnt_d    = 8'd0;
          end
        end
        pss_pkg::ACT_STOP: begin
          playing_d = 1'b0;
          busy_d    = 1'b1;
          jstop_d   = 1'b1;
          jemit_d   = 1'b0;
          slot_d    = 2'd0;
        end
        pss_pkg::ACT_TRIG: begin
          efreq_d  = {4'd0, in_i.effect_freq};
          erem_d   = in_i.effect_life;
          eslide_d = in_i.effect_slide;
          eduty_d  = in_i.effect_duty;
        end
        pss_pkg::ACT_WRITE: begin
          we_o = (int'(in_i.song) < SONGS) && (in_i.pattern_voice < pss_pkg::VOICE_FX)
                 && (int'(in_i.pattern_index) < STEPS);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      song_q    <= 2'd0;
      transp_q  <= 6'd0;
      step_q    <= '0;
      fcnt_q    <= 8'd0;
      efreq_q   <= 16'd0;
      erem_q    <= 5'd0;
      eslide_q  <= 8'sd0;
      eduty_q   <= 3'd0;
      busy_q    <= 1'b0;
      jstop_q   <= 1'b0;
      slot_q    <= 2'd0;
    end else begin
      playing_q <= playing_d;
      song_q    <= song_d;
      transp_q  <= transp_d;
      step_q    <= step_d;
      fcnt_q    <= fcnt_d;
      efreq_q   <= efreq_d;
      erem_q    <= erem_d;
      eslide_q  <= eslide_d;
      eduty_q   <= eduty_d;
      busy_q    <= busy_d;
      jstop_q   <= jstop_d;
      slot_q    <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jsong_q   <= jsong_d;
    jstep_q   <= jstep_d;
    jtransp_q <= jtransp_d;
    jemit_q   <= jemit_d;
    jsil_q    <= jsil_d;
    jpitch_q  <= jpitch_d;
    jvol_q    <= jvol_d;
    jduty_q   <= jduty_d;
  end

  // pattern reads for the three music slots of a tick job
  assign re_o    = fire & ~jstop_q & (slot_q != pss_pkg::VOICE_FX);
  assign raddr_o = AW'((int'(jsong_q) * 3 + int'(slot_q)) * STEPS + int'(jstep_q));

  always_comb begin
    slot_o           = '0;
    slot_o.vld       = fire;
    slot_o.stop      = jstop_q;
    slot_o.ch        = slot_q;
    slot_o.fin       = fin;
    slot_o.transp    = jtransp_q;
    slot_o.eff_emit  = jemit_q;
    slot_o.eff_sil   = jsil_q;
    slot_o.eff_pitch = jpitch_q;
    slot_o.eff_vol   = jvol_q;
    slot_o.eff_duty  = jduty_q;
  end

  `ASSERT_NEVER(a_rw_overlap, clk_i, rst_ni, we_o && re_o,
                "pattern write collides with a pattern read")
  `ASSERT_PROP(a_stop_job, clk_i, rst_ni,
               (acc && in_i.action == pss_pkg::ACT_STOP) |=>
               (busy_q && jstop_q && slot_q == 2'd0 && !playing_q),
               "stop did not start a stop job")
  `ASSERT_PROP(a_tick_job, clk_i, rst_ni,
               (acc && in_i.action == pss_pkg::ACT_TICK) |=> (busy_q && !jstop_q),
               "frame tick did not start a job")

endmodule

/* hdl/pss_fmt.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pss_fmt #(
  parameter int unsigned NOTES = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pss_pkg::pss_slot_t slot_i,
  input  logic [7:0]         rdata_i,
  output logic               b_vld_o,
  output logic               push_o,
  output pss_pkg::pss_res_t  push_data_o
);

  pss_pkg::pss_slot_t b_q;
  pss_pkg::pss_res_t  pend_q, pend_d, cand;
  logic               pend_vld_q, pend_vld_d;
  logic [8:0]         sum;

  assign sum     = {1'b0, rdata_i} + 9'(b_q.transp);
  assign b_vld_o = b_q.vld;

  // A music result waits in pend_q until the next result of the same item
  // shows up, so that the last one can be flagged when the effect is silent.
  always_comb begin
    cand        = '0;
    cand.voice  = b_q.ch;
    push_o      = 1'b0;
    push_data_o = '0;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    if (b_q.vld) begin
      if (b_q.stop) begin
        cand.silence = 1'b1;
        cand.last    = b_q.fin;
        push_o       = 1'b1;
        push_data_o  = cand;
      end else if (b_q.ch == pss_pkg::VOICE_FX) begin
        if (b_q.eff_emit) begin
          cand.silence = b_q.eff_sil;
          cand.pitch   = b_q.eff_pitch;
          cand.volume  = b_q.eff_vol;
          cand.duty    = b_q.eff_duty;
          cand.last    = 1'b1;
          push_o       = 1'b1;
          push_data_o  = cand;
        end else if (pend_vld_q) begin
          push_o           = 1'b1;
          push_data_o      = pend_q;
          push_data_o.last = 1'b1;
          pend_vld_d       = 1'b0;
        end
      end else if (rdata_i != pss_pkg::NOTE_HOLD) begin
        if (rdata_i == pss_pkg::NOTE_REST) begin
          cand.silence = 1'b1;
        end else begin
          cand.pitch  = (sum > 9'(NOTES - 1)) ? 16'(NOTES - 1) : 16'(sum);
          cand.volume = pss_pkg::music_vol(b_q.ch);
          cand.duty   = pss_pkg::music_duty(b_q.ch);
        end
        if (b_q.eff_emit) begin
          push_o      = 1'b1;
          push_data_o = cand;
        end else begin
          push_o      = pend_vld_q;
          push_data_o = pend_q;
          pend_d      = cand;
          pend_vld_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q        <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      b_q        <= slot_i;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  `ASSERT_NEVER(a_pend_with_fx, clk_i, rst_ni,
                b_q.vld && b_q.ch == pss_pkg::VOICE_FX && b_q.eff_emit && pend_vld_q,
                "held music result left behind an effect result")
  `ASSERT_PROP(a_pend_flushed, clk_i, rst_ni,
               (b_q.vld && !b_q.stop && b_q.ch == pss_pkg::VOICE_FX) |=> !pend_vld_q,
               "held music result survived the end of its item")

endmodule

/* hdl/pss_outq.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pss_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pss_pkg::pss_res_t push_data_i,
  input  logic              b_vld_i,
  output logic              room_o,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output pss_pkg::pss_res_t out_data_o
);

  localparam int unsigned PW = $clog2(pss_pkg::OUTQ_DEPTH);
  localparam int unsigned CW = $clog2(pss_pkg::OUTQ_DEPTH + 1);

  pss_pkg::pss_res_t q_q [pss_pkg::OUTQ_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign out_vld_o  = (cnt_q != '0);
  assign out_data_o = q_q[rd_q];
  assign pop        = out_vld_o & out_rdy_i;
  // one slot may issue only if its result and the one in flight both fit
  assign room_o     = (cnt_q + CW'(b_vld_i)) < CW'(pss_pkg::OUTQ_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni,
                push_i && !pop && cnt_q == CW'(pss_pkg::OUTQ_DEPTH),
                "result queue overflow")

endmodule

/* hdl/pattern_step_sequencer_with_sfx_voice_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tuser: action; tdata: song..pattern_note
// m_axis    out  m_axis_tvalid/tready       tuser: voice, silence; tdata: pitch,
//                                           volume, duty; tlast: last
// apb       in   psel & penable & pwrite    four frames-per-step registers at 4*i
//
// A frame tick that advances the step issues three pattern reads through the
// single RAM read port, then the effect slot. A stop issues one silencing
// slot per music voice, a tick without a step advance only the effect slot,
// and any other item none. Results leave through a 4-entry queue; input also
// stalls while that queue cannot take the next slot's result. Reset clears all
// control state; the pattern RAM is not cleared and needs no clearing pass.

module pattern_step_sequencer_with_sfx_voice_core #(
  parameter int unsigned STEPS = 32,
  parameter int unsigned SONGS = 4,
  parameter int unsigned NOTES = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // song, transpose, effect_freq, effect_life,
                                      // effect_slide, effect_duty, pattern_voice,
                                      // pattern_index, pattern_note, zero pad
  input  logic [2:0]  s_axis_tuser,   // action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pitch, volume, duty, zero pad
  output logic [2:0]  m_axis_tuser,   // voice, silence
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH = SONGS * 3 * STEPS;
  localparam int unsigned AW    = $clog2(DEPTH);

  pss_pkg::pss_in_t   in_item;
  pss_pkg::pss_slot_t slot;
  pss_pkg::pss_res_t  push_data, out_data;
  logic [3:0][7:0]    fps_q;
  logic               room, push, b_vld;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [7:0]         wdata, rdata;

  // unpack the input item, lowest field first
  always_comb begin
    in_item               = '0;
    in_item.action        = s_axis_tuser;
    in_item.song          = s_axis_tdata[1:0];
    in_item.transpose     = s_axis_tdata[7:2];
    in_item.effect_freq   = s_axis_tdata[19:8];
    in_item.effect_life   = s_axis_tdata[24:20];
    in_item.effect_slide  = s_axis_tdata[32:25];
    in_item.effect_duty   = s_axis_tdata[35:33];
    in_item.pattern_voice = s_axis_tdata[37:36];
    in_item.pattern_index = s_axis_tdata[42:38];
    in_item.pattern_note  = s_axis_tdata[50:43];
  end

  // frames-per-step registers; the user must write them only while the block is idle (not enforced by the block)
  assign pready = 1'b1;
  assign prdata = {24'd0, fps_q[paddr[3:2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q <= pss_pkg::FPS_RESET;
    end else if (psel && penable && pwrite) begin
      fps_q[paddr[3:2]] <= pwdata[7:0];
    end
  end

  // state, job sequencing and pattern RAM addressing
  pss_ctrl #(
    .STEPS(STEPS),
    .SONGS(SONGS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (s_axis_tvalid),
    .in_i     (in_item),
    .in_rdy_o (s_axis_tready),
    .fps_i    (fps_q),
    .room_i   (room),
    .slot_o   (slot),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .re_o     (re),
    .raddr_o  (raddr)
  );

  // pattern store: song-major, then voice, then step
  pss_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // note decode, clamp and last-flag resolution
  pss_fmt #(
    .NOTES(NOTES)
  ) u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_i      (slot),
    .rdata_i     (rdata),
    .b_vld_o     (b_vld),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pss_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .b_vld_i     (b_vld),
    .room_o      (room),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data.duty, out_data.volume, out_data.pitch};
  assign m_axis_tuser = {out_data.silence, out_data.voice};
  assign m_axis_tlast = out_data.last;

endmodule
